FILE: src/tsfpd_pkg.sv
// Shared types and constants for the two-sensor frame position decoder.
package tsfpd_pkg;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_SENSOR = 2'd1,
        OP_READ   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        REG_STOP_TICKS = 3'd0,
        REG_GAP_MIN    = 3'd1,
        REG_GAP_MAX    = 3'd2,
        REG_RUN_MIN    = 3'd3,
        REG_RUN_MAX    = 3'd4
    } cfg_index_t;

    localparam int CFG_WIDTH = 8;
    localparam int CFG_INDEX_WIDTH = 3;

    typedef logic [CFG_WIDTH-1:0] cfg_word_t;
    typedef logic signed [3:0]    frame_t;

    localparam cfg_word_t STOP_TICKS_RESET = 8'd250;
    localparam cfg_word_t GAP_MIN_RESET    = 8'd25;
    localparam cfg_word_t GAP_MAX_RESET    = 8'd150;
    localparam cfg_word_t RUN_MIN_RESET    = 8'd2;
    localparam cfg_word_t RUN_MAX_RESET    = 8'd7;
    localparam cfg_word_t RUNS_MAX         = 8'd255;

    localparam frame_t FRAME_UNKNOWN   = -4'sd1;
    localparam frame_t FRAME_FIRST     = 4'sd1;
    localparam frame_t FRAME_LAST      = 4'sd6;
    localparam frame_t FRAME_JUMP_UP   = 4'sd2;
    localparam frame_t FRAME_JUMP_DOWN = 4'sd5;

endpackage

FILE: src/two_sensor_frame_position_decoder.sv
// The output register loads each transaction's result at the edge that accepts it.
// Throughput: one transaction per cycle while out_stall is low; all state updates in one
//   pass at the accept edge, and the single output register refills as it is taken.
// Reset (rst_n low, async): frame unknown (-1), event flag set, last-read frame 1,
//   config registers at 250 / 25 / 150 / 2 / 7, counters and direction bits cleared.
module two_sensor_frame_position_decoder
    import tsfpd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    // input channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [1:0]                 op,
    input  logic                       sensor_a,
    input  logic                       sensor_b,
    // output channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [3:0]          frame_number,
    output logic                       frame_event,
    output logic [7:0]                 pulse_gap,
    // configuration write port
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    cfg_word_t stop_ticks_reg, gap_min_reg, gap_max_reg, run_min_reg, run_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stop_ticks_reg <= STOP_TICKS_RESET;
            gap_min_reg    <= GAP_MIN_RESET;
            gap_max_reg    <= GAP_MAX_RESET;
            run_min_reg    <= RUN_MIN_RESET;
            run_max_reg    <= RUN_MAX_RESET;
        end
        else if (cfg_we)
        begin
            // indexes past the register list are dropped
            unique case (cfg_index)
                REG_STOP_TICKS: stop_ticks_reg <= cfg_data;
                REG_GAP_MIN:    gap_min_reg    <= cfg_data;
                REG_GAP_MAX:    gap_max_reg    <= cfg_data;
                REG_RUN_MIN:    run_min_reg    <= cfg_data;
                REG_RUN_MAX:    run_max_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Handshake: the output register frees up in the cycle it is taken
    // ---------------------------------------------------------------
    logic out_valid_reg;
    logic in_accept;
    op_t  op_in;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;
    assign op_in     = op_t'(op);

    // ---------------------------------------------------------------
    // Decoder state
    // ---------------------------------------------------------------
    logic [7:0] tick_count_reg,  tick_count_next;
    logic       count_enable_reg, count_enable_next;
    logic       both_high_reg,   both_high_next;
    logic       dir_up_reg,      dir_up_next;
    logic       prev_dir_up_reg, prev_dir_up_next;
    logic [7:0] left_runs_reg,   left_runs_next;
    logic [7:0] right_runs_reg,  right_runs_next;
    frame_t     frame_reg,       frame_next;
    frame_t     last_read_reg,   last_read_next;
    logic       event_reg,       event_next;
    logic       awaiting_reg,    awaiting_next;
    logic [7:0] last_gap_reg,    last_gap_next;

    // Settle: new frame from run counts and old/new direction
    logic              step_left, step_right;
    logic signed [4:0] frame_ext;
    logic signed [4:0] settle_raw;
    frame_t            settle_frame;
    logic              settle_clears_wait;

    assign step_left  = (left_runs_reg >= run_min_reg) && (left_runs_reg <= run_max_reg);
    assign step_right = (right_runs_reg >= run_min_reg) && (right_runs_reg <= run_max_reg);
    assign frame_ext  = {frame_reg[3], frame_reg};

    always_comb
    begin
        priority if (step_left || step_right)
        begin
            unique case ({dir_up_reg, prev_dir_up_reg})
                2'b11:   settle_raw = frame_ext + 5'sd1;
                2'b00:   settle_raw = frame_ext - 5'sd1;
                2'b01:   settle_raw = {FRAME_JUMP_DOWN[3], FRAME_JUMP_DOWN};
                default: settle_raw = {FRAME_JUMP_UP[3], FRAME_JUMP_UP};
            endcase
        end
        else if (right_runs_reg < run_min_reg)
            settle_raw = {FRAME_LAST[3], FRAME_LAST};
        else if (left_runs_reg < run_min_reg)
            settle_raw = {FRAME_FIRST[3], FRAME_FIRST};
        else
            settle_raw = {FRAME_UNKNOWN[3], FRAME_UNKNOWN};

        // stepping off either end gives unknown
        if (settle_raw < {FRAME_FIRST[3], FRAME_FIRST} || settle_raw > {FRAME_LAST[3], FRAME_LAST})
            settle_frame = FRAME_UNKNOWN;
        else
            settle_frame = settle_raw[3:0];

        // until an end frame has been seen, hold unknown
        settle_clears_wait = 1'b0;
        if (awaiting_reg)
        begin
            if (settle_frame == FRAME_FIRST || settle_frame == FRAME_LAST)
                settle_clears_wait = 1'b1;
            else
                settle_frame = FRAME_UNKNOWN;
        end
    end

    // Pulse window check uses the tick count before this transaction
    logic gap_ok;
    logic pulse_ok;

    assign gap_ok   = (tick_count_reg >= gap_min_reg) && (tick_count_reg < gap_max_reg);
    assign pulse_ok = gap_ok && both_high_reg;

    always_comb
    begin
        tick_count_next   = tick_count_reg;
        count_enable_next = count_enable_reg;
        both_high_next    = both_high_reg;
        dir_up_next       = dir_up_reg;
        prev_dir_up_next  = prev_dir_up_reg;
        left_runs_next    = left_runs_reg;
        right_runs_next   = right_runs_reg;
        frame_next        = frame_reg;
        last_read_next    = last_read_reg;
        event_next        = event_reg;
        awaiting_next     = awaiting_reg;
        last_gap_next     = last_gap_reg;

        unique case (op_in)
            OP_TICK:
            begin
                if (count_enable_reg)
                begin
                    if (tick_count_reg >= stop_ticks_reg)
                    begin
                        count_enable_next = 1'b0;
                        frame_next        = settle_frame;
                        left_runs_next    = '0;
                        right_runs_next   = '0;
                        prev_dir_up_next  = dir_up_reg;
                        if (settle_clears_wait)
                            awaiting_next = 1'b0;
                        if (last_read_reg != settle_frame)
                            event_next = 1'b1;
                    end
                    else
                        tick_count_next = tick_count_reg + 8'd1;
                end
            end
            OP_SENSOR:
            begin
                unique case ({sensor_a, sensor_b})
                    2'b11: both_high_next = 1'b1;
                    2'b01:
                    begin
                        // left pulse
                        if (pulse_ok)
                        begin
                            last_gap_next   = tick_count_reg;
                            dir_up_next     = 1'b1;
                            left_runs_next  = (left_runs_reg == RUNS_MAX) ? left_runs_reg
                                                                          : left_runs_reg + 8'd1;
                            right_runs_next = '0;
                        end
                        both_high_next = 1'b0;
                    end
                    2'b10:
                    begin
                        // right pulse
                        if (pulse_ok)
                        begin
                            last_gap_next   = tick_count_reg;
                            dir_up_next     = 1'b0;
                            right_runs_next = (right_runs_reg == RUNS_MAX) ? right_runs_reg
                                                                           : right_runs_reg + 8'd1;
                            left_runs_next  = '0;
                        end
                        both_high_next = 1'b0;
                    end
                    default: ; // both low keeps pulse state
                endcase
                count_enable_next = 1'b1;
                tick_count_next   = '0;
            end
            OP_READ:
            begin
                event_next     = 1'b0;
                last_read_next = frame_reg;
            end
            default: ; // unused code: state unchanged, result still reported
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg   <= '0;
            count_enable_reg <= 1'b0;
            both_high_reg    <= 1'b0;
            dir_up_reg       <= 1'b0;
            prev_dir_up_reg  <= 1'b0;
            left_runs_reg    <= '0;
            right_runs_reg   <= '0;
            frame_reg        <= FRAME_UNKNOWN;
            last_read_reg    <= FRAME_FIRST;
            event_reg        <= 1'b1;
            awaiting_reg     <= 1'b1;
            last_gap_reg     <= '0;
        end
        else if (in_accept)
        begin
            tick_count_reg   <= tick_count_next;
            count_enable_reg <= count_enable_next;
            both_high_reg    <= both_high_next;
            dir_up_reg       <= dir_up_next;
            prev_dir_up_reg  <= prev_dir_up_next;
            left_runs_reg    <= left_runs_next;
            right_runs_reg   <= right_runs_next;
            frame_reg        <= frame_next;
            last_read_reg    <= last_read_next;
            event_reg        <= event_next;
            awaiting_reg     <= awaiting_next;
            last_gap_reg     <= last_gap_next;
        end
    end

    // ---------------------------------------------------------------
    // Output register: one result per transaction, post-update values
    // ---------------------------------------------------------------
    frame_t     out_frame_reg;
    logic       out_event_reg;
    logic [7:0] out_gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_frame_reg <= frame_next;
            out_event_reg <= event_next;
            out_gap_reg   <= last_gap_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_number = out_frame_reg;
    assign frame_event  = out_event_reg;
    assign pulse_gap    = out_gap_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_wait_forces_unknown: assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_reg |-> (frame_reg == FRAME_UNKNOWN))
        else $error("frame known before an end frame was seen");

    a_frame_range: assert property (@(posedge clk) disable iff (!rst_n)
        (frame_reg == FRAME_UNKNOWN) || ((frame_reg >= FRAME_FIRST) && (frame_reg <= FRAME_LAST)))
        else $error("frame out of range");

    a_read_clears_event: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && op_in == OP_READ) |=> (!event_reg && out_valid_reg && !out_event_reg))
        else $error("read acknowledge did not clear the new-frame flag");

endmodule

FILE: verif/frame_decoder_checker.sv
// Checker for the frame decoder: tracks its own decoder state and compares every output.
`timescale 1ns / 100ps

module frame_decoder_checker
    import tsfpd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [1:0]                 op,
    input  logic                       sensor_a,
    input  logic                       sensor_b,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic signed [3:0]          frame_number,
    input  logic                       frame_event,
    input  logic [7:0]                 pulse_gap,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]       cfg_data,
    output int                         fail_count,
    output int                         outstanding
);

    typedef struct {
        frame_t     frame_number;
        logic       frame_event;
        logic [7:0] pulse_gap;
    } frame_report_t;

    frame_report_t pending_frames[$];

    int failures = 0;
    int waiting  = 0;

    assign fail_count  = failures;
    assign outstanding = waiting;

    // settings
    cfg_word_t cfg_stop, cfg_gap_lo, cfg_gap_hi, cfg_run_lo, cfg_run_hi;

    // decoder state
    logic [7:0] tick_cnt;
    logic       counting;
    logic       pulse_open;
    logic       moving_up;
    logic       was_moving_up;
    logic [7:0] left_run;
    logic [7:0] right_run;
    frame_t     frame;
    frame_t     frame_read;
    logic       new_frame;
    logic       need_end_frame;
    logic [7:0] gap_seen;

    task automatic reset_decoder();
        cfg_stop       = STOP_TICKS_RESET;
        cfg_gap_lo     = GAP_MIN_RESET;
        cfg_gap_hi     = GAP_MAX_RESET;
        cfg_run_lo     = RUN_MIN_RESET;
        cfg_run_hi     = RUN_MAX_RESET;
        tick_cnt       = '0;
        counting       = 1'b0;
        pulse_open     = 1'b0;
        moving_up      = 1'b0;
        was_moving_up  = 1'b0;
        left_run       = '0;
        right_run      = '0;
        frame          = FRAME_UNKNOWN;
        frame_read     = FRAME_FIRST;
        new_frame      = 1'b1;
        need_end_frame = 1'b1;
        gap_seen       = '0;
    endtask

    function automatic logic run_means_step(logic [7:0] runs);
        return runs >= cfg_run_lo && runs <= cfg_run_hi;
    endfunction

    function automatic logic [7:0] bump_run(logic [7:0] runs);
        return (runs == RUNS_MAX) ? runs : runs + 8'd1;
    endfunction

    // Quiet time expired: decide the frame from run counts and directions.
    task automatic settle_frame();
        int f;
        f = int'(frame);
        counting = 1'b0;
        if (run_means_step(right_run) || run_means_step(left_run))
        begin
            if (moving_up && was_moving_up)
                f = f + 1;
            else if (!moving_up && !was_moving_up)
                f = f - 1;
            else if (!moving_up && was_moving_up)
                f = int'(FRAME_JUMP_DOWN);
            else
                f = int'(FRAME_JUMP_UP);
        end
        else if (right_run < cfg_run_lo)
            f = int'(FRAME_LAST);
        else if (left_run < cfg_run_lo)
            f = int'(FRAME_FIRST);
        else
            f = int'(FRAME_UNKNOWN);
        if (f < int'(FRAME_FIRST) || f > int'(FRAME_LAST))
            f = int'(FRAME_UNKNOWN);
        if (need_end_frame)
        begin
            if (f == int'(FRAME_FIRST) || f == int'(FRAME_LAST))
                need_end_frame = 1'b0;
            else
                f = int'(FRAME_UNKNOWN);
        end
        frame     = frame_t'(f);
        left_run  = '0;
        right_run = '0;
        if (frame_read != frame)
            new_frame = 1'b1;
        was_moving_up = moving_up;
    endtask

    task automatic decode_transaction(op_t code, logic a, logic b);
        logic          gap_ok;
        frame_report_t rpt;
        gap_ok = tick_cnt >= cfg_gap_lo && tick_cnt < cfg_gap_hi;
        case (code)
            OP_TICK:
            begin
                if (counting)
                begin
                    if (tick_cnt >= cfg_stop)
                        settle_frame();
                    else
                        tick_cnt = tick_cnt + 8'd1;
                end
            end
            OP_SENSOR:
            begin
                if (a && b)
                    pulse_open = 1'b1;
                else if (a != b)
                begin
                    if (gap_ok && pulse_open)
                    begin
                        gap_seen  = tick_cnt;
                        moving_up = b;
                        if (b)
                        begin
                            left_run  = bump_run(left_run);
                            right_run = '0;
                        end
                        else
                        begin
                            right_run = bump_run(right_run);
                            left_run  = '0;
                        end
                    end
                    pulse_open = 1'b0;
                end
                counting = 1'b1;
                tick_cnt = '0;
            end
            OP_READ:
            begin
                new_frame  = 1'b0;
                frame_read = frame;
            end
            default: ;
        endcase
        rpt.frame_number = frame;
        rpt.frame_event  = new_frame;
        rpt.pulse_gap    = gap_seen;
        pending_frames.push_back(rpt);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_report_t want;
        if (!rst_n)
        begin
            reset_decoder();
            pending_frames.delete();
            waiting = 0;
        end
        else
        begin
            // output first: a result can never come from this edge's input
            if (out_valid && !out_stall)
            begin
                if (pending_frames.size() == 0)
                begin
                    $error("unexpected result: frame_number %0d with no transaction pending",
                           frame_number);
                    failures++;
                end
                else
                begin
                    want = pending_frames.pop_front();
                    if (frame_number !== want.frame_number)
                    begin
                        $error("frame_number: expected %0d, actual %0d",
                               want.frame_number, frame_number);
                        failures++;
                    end
                    if (frame_event !== want.frame_event)
                    begin
                        $error("frame_event: expected %0d, actual %0d",
                               want.frame_event, frame_event);
                        failures++;
                    end
                    if (pulse_gap !== want.pulse_gap)
                    begin
                        $error("pulse_gap: expected %0d, actual %0d",
                               want.pulse_gap, pulse_gap);
                        failures++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_index))
                    REG_STOP_TICKS: cfg_stop   = cfg_data;
                    REG_GAP_MIN:    cfg_gap_lo = cfg_data;
                    REG_GAP_MAX:    cfg_gap_hi = cfg_data;
                    REG_RUN_MIN:    cfg_run_lo = cfg_data;
                    REG_RUN_MAX:    cfg_run_hi = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                decode_transaction(op_t'(op), sensor_a, sensor_b);
            waiting = pending_frames.size();
        end
    end

endmodule

FILE: verif/tb_two_sensor_frame_position_decoder.sv
// Testbench top for the frame decoder: stimulus, idling, settings phases and the verdict.
`timescale 1ns / 100ps

module tb_two_sensor_frame_position_decoder;
    import tsfpd_pkg::*;

    // Generous bound; a correct run needs a small fraction of this.
    localparam int CYCLE_LIMIT = 400000;

    // Every input starts at a known value.
    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic [1:0]                 op        = OP_TICK;
    logic                       sensor_a  = 1'b0;
    logic                       sensor_b  = 1'b0;
    logic                       out_stall = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_STOP_TICKS;
    logic [CFG_WIDTH-1:0]       cfg_data  = '0;

    logic                       in_stall;
    logic                       out_valid;
    logic signed [3:0]          frame_number;
    logic                       frame_event;
    logic [7:0]                 pulse_gap;

    int fail_count;
    int outstanding;

    // Settings currently loaded; only used to shape the stimulus.
    cfg_word_t cur_stop   = STOP_TICKS_RESET;
    cfg_word_t cur_gap_lo = GAP_MIN_RESET;
    cfg_word_t cur_gap_hi = GAP_MAX_RESET;

    bit calm        = 1'b0;   // no idling on either side once set
    int item_count  = 0;
    int cycle_count = 0;

    always #5 clk = ~clk;

    two_sensor_frame_position_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .sensor_a     (sensor_a),
        .sensor_b     (sensor_b),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_number (frame_number),
        .frame_event  (frame_event),
        .pulse_gap    (pulse_gap),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    frame_decoder_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .op           (op),
        .sensor_a     (sensor_a),
        .sensor_b     (sensor_b),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_number (frame_number),
        .frame_event  (frame_event),
        .pulse_gap    (pulse_gap),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    // Watchdog: a hang or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver back-pressure: stall bursts of random length, with quiet stretches.
    always
    begin
        @(negedge clk);
        if (!calm && rst_n && $urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            out_stall <= 1'b0;
        end
        else if ($urandom_range(0, 15) == 0)
            repeat ($urandom_range(20, 60)) @(negedge clk);
    end

    // One input transaction. Entered and left at a falling edge; valid stays
    // high between back-to-back transactions so it is never dropped and
    // raised in the same step.
    task automatic send(op_t code, bit a, bit b);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= code;
        sensor_a <= a;
        sensor_b <= b;
        do
            @(posedge clk);
        while (in_stall);
        item_count++;
        @(negedge clk);
    endtask

    // Ticks carry random sensor bits; the block must ignore them.
    task automatic ticks(int n);
        repeat (n) send(OP_TICK, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic change(bit a, bit b);
        send(OP_SENSOR, a, b);
    endtask

    task automatic noise();
        send(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
             1'($urandom_range(0, 1)));
    endtask

    // Both sensors high, a gap of ticks, then one sensor drops.
    // Up means the first sensor drops first.
    task automatic pulse(bit up, int gap);
        change(1'b1, 1'b1);
        ticks(gap);
        change(!up, up);
    endtask

    // Let every pending result drain so the block is idle.
    task automatic drain();
        in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic put_reg(cfg_index_t idx, cfg_word_t value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    // Write enable stays high across the five writes, dropped once after.
    task automatic load_settings(cfg_word_t stop, cfg_word_t gap_lo, cfg_word_t gap_hi,
                                 cfg_word_t run_lo, cfg_word_t run_hi);
        drain();
        put_reg(REG_STOP_TICKS, stop);
        put_reg(REG_GAP_MIN, gap_lo);
        put_reg(REG_GAP_MAX, gap_hi);
        put_reg(REG_RUN_MIN, run_lo);
        put_reg(REG_RUN_MAX, run_hi);
        cfg_we     <= 1'b0;
        cur_stop   = stop;
        cur_gap_lo = gap_lo;
        cur_gap_hi = gap_hi;
    endtask

    // Mostly a gap inside the accept window (and short of settling),
    // sometimes anywhere, so rejected and settling-mid-pulse cases show up.
    function automatic int pick_gap();
        int lo;
        int hi;
        lo = int'(cur_gap_lo);
        hi = int'(cur_gap_hi) - 1;
        if (hi > int'(cur_stop))
            hi = int'(cur_stop);
        if (lo <= hi && $urandom_range(0, 4) != 0)
            return $urandom_range(lo, hi);
        hi = int'(cur_gap_hi) + 2;
        if (hi > int'(cur_stop) + 1)
            hi = int'(cur_stop) + 1;
        return $urandom_range(0, hi);
    endfunction

    // One scroll: a run of pulses, some broken, then enough quiet ticks to settle.
    task automatic gesture();
        bit up;
        int pulses;
        int kind;
        up     = 1'($urandom_range(0, 1));
        pulses = $urandom_range(0, 9);
        for (int i = 0; i < pulses; i++)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
                change(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else if (kind == 1)
                send(OP_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else
            begin
                if (kind == 2)
                    up = !up;
                pulse(up, pick_gap());
            end
            if ($urandom_range(0, 5) == 0)
                ticks($urandom_range(0, 1));
        end
        ticks(int'(cur_stop) + 1 + $urandom_range(0, 2));
        if ($urandom_range(0, 2) == 0)
            send(OP_READ, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic random_phase(int n);
        int start;
        start = item_count;
        while (item_count - start < n)
        begin
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 4)) noise();
            else
                gesture();
        end
    endtask

    initial
    begin
        int s;
        int gl;
        int gh;
        int rl;
        int rh;

        // Reset held, then released away from the rising edge.
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset settings. Unused op code, read, tick while counting
        // is off, both sensors low (restarts counting), a too-short pulse.
        send(OP_NONE, 1'b1, 1'b1);
        send(OP_READ, 1'b1, 1'b0);
        send(OP_TICK, 1'b0, 1'b1);
        change(1'b0, 1'b0);
        ticks(1);
        change(1'b1, 1'b1);
        change(1'b1, 1'b0);
        send(OP_READ, 1'b0, 1'b0);

        // Directed: zero quiet ticks, so the first tick settles. Steps before
        // an end frame stay unknown; no pulses gives the last frame; turning up
        // from there jumps to frame 2, and the next step up moves to frame 3.
        load_settings(8'd0, 8'd0, 8'd2, 8'd1, 8'd2);
        pulse(1'b1, 0);
        ticks(1);
        pulse(1'b0, 0);
        ticks(1);
        change(1'b0, 1'b0);
        ticks(2);
        send(OP_READ, 1'b1, 1'b1);
        pulse(1'b1, 0);
        ticks(1);
        pulse(1'b1, 0);
        ticks(1);

        // Small window, regular scrolling.
        load_settings(8'd4, 8'd1, 8'd5, 8'd2, 8'd4);
        random_phase(25);

        // Zero quiet ticks under random traffic.
        load_settings(8'd0, 8'd0, 8'd2, 8'd1, 8'd2);
        random_phase(20);

        // Widest window; only a run count held at 255 reads as a step, so a
        // counter that wraps past 255 settles differently.
        load_settings(8'd1, 8'd0, 8'd255, 8'd255, 8'd255);
        repeat (256) pulse(1'b1, 0);
        ticks(3);

        // Empty window (min above max): no pulse is ever accepted.
        load_settings(8'd4, 8'd5, 8'd2, 8'd1, 8'd3);
        gesture();

        // Reset values written back explicitly.
        load_settings(STOP_TICKS_RESET, GAP_MIN_RESET, GAP_MAX_RESET,
                      RUN_MIN_RESET, RUN_MAX_RESET);
        repeat (4) noise();

        // Random small settings; the last phase runs without any idling.
        for (int p = 0; p < 3; p++)
        begin
            s  = $urandom_range(3, 10);
            gl = $urandom_range(0, 2);
            gh = $urandom_range(gl + 1, s + 1);
            rl = $urandom_range(0, 3);
            rh = rl + $urandom_range(0, 4);
            if ($urandom_range(0, 5) == 0)
                rh = $urandom_range(0, rl);
            load_settings(cfg_word_t'(s), cfg_word_t'(gl), cfg_word_t'(gh),
                          cfg_word_t'(rl), cfg_word_t'(rh));
            if (p == 2)
                calm = 1'b1;
            random_phase(25);
        end

        drain();
        repeat (2) @(negedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
